// ===== hdl/hpc_pkg.sv =====
`timescale 1ns / 1ps

package hpc_pkg;

    localparam int MAX_VERTS   = 16;
    localparam int STORE_DEPTH = 32;
    localparam int T_BITS      = 30;
    localparam int IN_CAP  = (MAX_VERTS < STORE_DEPTH) ? MAX_VERTS : STORE_DEPTH;
    localparam int OUT_CAP = ((MAX_VERTS + 4) < STORE_DEPTH) ? (MAX_VERTS + 4) : STORE_DEPTH;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int DW  = 52;                      // plane distance, signed
    localparam int TCW = $clog2(T_BITS + 1);

    localparam logic signed [15:0] RST_X_MIN = 16'sd0;
    localparam logic signed [15:0] RST_X_MAX = 16'sd640;
    localparam logic signed [15:0] RST_Y_MIN = 16'sd0;
    localparam logic signed [15:0] RST_Y_MAX = 16'sd480;

    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_X_MAX = 2'd1,
        REG_Y_MIN = 2'd2,
        REG_Y_MAX = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_w;
        logic               final_vertex;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_w;
        logic               run_end;
        logic               nothing_left;
        logic               overflow;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] w;
    } vtx_t;

    typedef enum logic [4:0] {
        OP_NOP        = 5'd0,
        OP_LOAD       = 5'd1,
        OP_MUL        = 5'd2,
        OP_CODE       = 5'd3,
        OP_ACC        = 5'd4,
        OP_PLANE_CLR  = 5'd5,
        OP_PLANE_NEXT = 5'd6,
        OP_PASS_START = 5'd7,
        OP_RD         = 5'd8,
        OP_FETCH      = 5'd9,
        OP_DIST       = 5'd10,
        OP_DIV_START  = 5'd11,
        OP_LMUL       = 5'd12,
        OP_LADD       = 5'd13,
        OP_WR_INT     = 5'd14,
        OP_WR_CUR     = 5'd15,
        OP_KINC       = 5'd16,
        OP_PASS_END   = 5'd17,
        OP_EMIT_START = 5'd18,
        OP_EMIT       = 5'd19,
        OP_EMPTY      = 5'd20,
        OP_EMPTY_OVF  = 5'd21,
        OP_CLEAR      = 5'd22
    } dp_op_t;

    typedef struct packed {
        logic final_flag;
        logic ovf_flag;
        logic degen;
        logic reject;
        logic plane_on;
        logic plane_last;
        logic n_lt3;
        logic k_is0;
        logic k_eq_n;
        logic k_last;
        logic crossing;
        logic keep;
        logic cap_full;
        logic div_busy;
        logic comp_last;
    } dp_status_t;

endpackage

// ===== hdl/hpc_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; num < den assumed
module hpc_div
    import hpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [DW-1:0]     num,
    input  logic [DW-1:0]     den,
    output logic              busy,
    output logic [T_BITS-1:0] quo
);

    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     den_reg;
    logic [T_BITS-1:0] q_reg;
    logic [TCW-1:0]    cnt_reg;
    logic              busy_reg;
    logic [DW:0]       rem2;
    logic              take;

    assign rem2 = {rem_reg, 1'b0};
    assign take = (rem2 >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= TCW'(T_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != TCW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? DW'(rem2 - {1'b0, den_reg}) : rem2[DW-1:0];
            q_reg   <= {q_reg[T_BITS-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

// ===== hdl/hpc_datapath.sv =====
`timescale 1ns / 1ps

module hpc_datapath
    import hpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_op_t     op,
    input  in_word_t   vertex,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    output dp_status_t status,
    output logic       result_valid,
    output out_word_t  result
);

    logic signed [15:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    vtx_t               cur_reg, prev_reg, rdat;
    logic               final_reg, load_ok_reg, ovf_reg, src_sel_reg;
    logic [CW-1:0]      vcount_reg, n_reg, k_reg, cnt_reg;
    logic [3:0]         or_reg, and_reg, code_reg;
    logic [1:0]         plane_reg, comp_reg;
    logic signed [49:0] prod_reg, prod_next;
    logic signed [33:0] c2_reg;
    logic signed [DW-1:0] d_reg, dprev_reg, d_comb, prod_x, c2_x;
    logic signed [DW:0] dd;
    logic [DW-1:0]      num, den;
    logic signed [15:0] rsel;
    logic signed [17:0] coef;
    logic signed [31:0] coord;
    logic               div_busy;
    logic [T_BITS-1:0]  t;
    logic signed [31:0] cur_c, prev_c;
    logic signed [32:0] ldiff;
    logic [32:0]        lmag;
    logic [62:0]        lprod_reg, lprod_next;
    logic               lneg_reg;
    logic [63:0]        lsum;
    logic [33:0]        lr, lbase, lres;
    logic [31:0]        ires_reg [0:2];
    vtx_t               mem_a [0:STORE_DEPTH-1];
    vtx_t               mem_b [0:STORE_DEPTH-1];
    vtx_t               rd_a_reg, rd_b_reg, wr_data;
    logic               we_a, we_b, wr_op, room;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic               result_valid_reg;
    out_word_t          result_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg <= RST_X_MIN;
            xmax_reg <= RST_X_MAX;
            ymin_reg <= RST_Y_MIN;
            ymax_reg <= RST_Y_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_X_MIN: xmin_reg <= cfg_data;
                REG_X_MAX: xmax_reg <= cfg_data;
                REG_Y_MIN: ymin_reg <= cfg_data;
                REG_Y_MAX: ymax_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // plane distance: coefficient (2*edge-1) times w, against 2*coord
    always_comb
    begin
        case (plane_reg)
            2'd0:    rsel = xmin_reg;
            2'd1:    rsel = xmax_reg;
            2'd2:    rsel = ymin_reg;
            default: rsel = ymax_reg;
        endcase
    end

    assign coef      = $signed({rsel[15], rsel, 1'b0}) - 18'sd1;
    assign coord     = plane_reg[1] ? cur_reg.y : cur_reg.x;
    assign prod_next = coef * cur_reg.w;
    assign prod_x    = {{(DW-50){prod_reg[49]}}, prod_reg};
    assign c2_x      = {{(DW-34){c2_reg[33]}}, c2_reg};
    assign d_comb    = plane_reg[0] ? (prod_x - c2_x) : (c2_x - prod_x);

    assign dd  = {d_reg[DW-1], d_reg} - {dprev_reg[DW-1], dprev_reg};
    assign num = d_reg[DW-1] ? DW'(-d_reg) : d_reg;
    assign den = dd[DW] ? DW'(-dd) : dd[DW-1:0];

    hpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (op == OP_DIV_START),
        .num   (num),
        .den   (den),
        .busy  (div_busy),
        .quo   (t)
    );

    // interpolation, one component at a time
    always_comb
    begin
        case (comp_reg)
            2'd0:    begin cur_c = cur_reg.x; prev_c = prev_reg.x; end
            2'd1:    begin cur_c = cur_reg.y; prev_c = prev_reg.y; end
            default: begin cur_c = cur_reg.w; prev_c = prev_reg.w; end
        endcase
    end

    assign ldiff      = {prev_c[31], prev_c} - {cur_c[31], cur_c};
    assign lmag       = ldiff[32] ? 33'(-ldiff) : 33'(ldiff);
    assign lprod_next = {30'd0, lmag} * {33'd0, t};
    assign lsum       = {1'b0, lprod_reg} + (64'd1 << (T_BITS - 1));
    assign lr         = lsum[63:T_BITS];
    assign lbase      = {{2{cur_c[31]}}, cur_c};
    assign lres       = lneg_reg ? (lbase - lr) : (lbase + lr);

    // stores
    assign room    = (vcount_reg < CW'(IN_CAP));
    assign wr_op   = (op == OP_WR_INT) || (op == OP_WR_CUR);
    assign we_a    = ((op == OP_LOAD) && room) || (wr_op && src_sel_reg);
    assign we_b    = wr_op && !src_sel_reg;
    assign wr_addr = (op == OP_LOAD) ? vcount_reg[AW-1:0] : cnt_reg[AW-1:0];
    assign rd_addr = (k_reg == n_reg) ? '0 : k_reg[AW-1:0];

    always_comb
    begin
        if (op == OP_LOAD)
            wr_data = {vertex.vert_x, vertex.vert_y, vertex.vert_w};
        else if (op == OP_WR_INT)
            wr_data = {ires_reg[0], ires_reg[1], ires_reg[2]};
        else
            wr_data = cur_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[wr_addr] <= wr_data;
        if (we_b)
            mem_b[wr_addr] <= wr_data;
        if (op == OP_RD)
        begin
            rd_a_reg <= mem_a[rd_addr];
            rd_b_reg <= mem_b[rd_addr];
        end
    end

    assign rdat = src_sel_reg ? rd_b_reg : rd_a_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg  <= '0;
            or_reg      <= '0;
            and_reg     <= 4'hF;
            ovf_reg     <= 1'b0;
            load_ok_reg <= 1'b0;
            final_reg   <= 1'b0;
            code_reg    <= '0;
            plane_reg   <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            cnt_reg     <= '0;
            src_sel_reg <= 1'b0;
            comp_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (op == OP_EMIT) || (op == OP_EMPTY) || (op == OP_EMPTY_OVF);
            case (op)
                OP_LOAD:
                begin
                    load_ok_reg <= room;
                    final_reg   <= vertex.final_vertex;
                    plane_reg   <= '0;
                    if (room)
                        vcount_reg <= vcount_reg + 1'b1;
                    else
                        ovf_reg <= 1'b1;
                end
                OP_CODE:
                begin
                    code_reg[plane_reg] <= d_comb[DW-1];
                    plane_reg <= plane_reg + 1'b1;
                end
                OP_ACC:
                begin
                    if (load_ok_reg)
                    begin
                        or_reg  <= or_reg | code_reg;
                        and_reg <= and_reg & code_reg;
                    end
                end
                OP_PLANE_CLR:
                begin
                    plane_reg   <= '0;
                    n_reg       <= vcount_reg;
                    src_sel_reg <= 1'b0;
                end
                OP_PLANE_NEXT: plane_reg <= plane_reg + 1'b1;
                OP_PASS_START:
                begin
                    k_reg   <= '0;
                    cnt_reg <= '0;
                end
                OP_DIV_START:  comp_reg <= '0;
                OP_LADD:       comp_reg <= comp_reg + 1'b1;
                OP_WR_INT, OP_WR_CUR: cnt_reg <= cnt_reg + 1'b1;
                OP_KINC:       k_reg <= k_reg + 1'b1;
                OP_PASS_END:
                begin
                    n_reg       <= cnt_reg;
                    src_sel_reg <= !src_sel_reg;
                end
                OP_EMIT_START: k_reg <= '0;
                OP_EMIT:       k_reg <= k_reg + 1'b1;
                OP_CLEAR:
                begin
                    vcount_reg <= '0;
                    or_reg     <= '0;
                    and_reg    <= 4'hF;
                    ovf_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:  cur_reg <= {vertex.vert_x, vertex.vert_y, vertex.vert_w};
            OP_MUL:
            begin
                prod_reg <= prod_next;
                c2_reg   <= {coord[31], coord, 1'b0};
            end
            OP_FETCH:
            begin
                prev_reg  <= cur_reg;
                dprev_reg <= d_reg;
                cur_reg   <= rdat;
            end
            OP_DIST:  d_reg <= d_comb;
            OP_LMUL:
            begin
                lprod_reg <= lprod_next;
                lneg_reg  <= ldiff[32];
            end
            OP_LADD:  ires_reg[comp_reg] <= lres[31:0];
            OP_EMIT:
            begin
                result_reg.out_x        <= rdat.x;
                result_reg.out_y        <= rdat.y;
                result_reg.out_w        <= rdat.w;
                result_reg.run_end      <= (k_reg + 1'b1 == n_reg);
                result_reg.nothing_left <= 1'b0;
                result_reg.overflow     <= 1'b0;
            end
            OP_EMPTY, OP_EMPTY_OVF:
            begin
                result_reg.out_x        <= '0;
                result_reg.out_y        <= '0;
                result_reg.out_w        <= '0;
                result_reg.run_end      <= 1'b1;
                result_reg.nothing_left <= 1'b1;
                result_reg.overflow     <= (op == OP_EMPTY_OVF);
            end
            default: ;
        endcase
    end

    assign status.final_flag = final_reg;
    assign status.ovf_flag   = ovf_reg;
    assign status.degen      = (xmax_reg <= xmin_reg) || (ymax_reg <= ymin_reg);
    assign status.reject     = (and_reg != 4'h0);
    assign status.plane_on   = or_reg[plane_reg];
    assign status.plane_last = (plane_reg == 2'd3);
    assign status.n_lt3      = (n_reg < CW'(3));
    assign status.k_is0      = (k_reg == '0);
    assign status.k_eq_n     = (k_reg == n_reg);
    assign status.k_last     = (k_reg + 1'b1 == n_reg);
    assign status.crossing   = (!dprev_reg[DW-1] && (dprev_reg != '0) && d_reg[DW-1])
                            || (dprev_reg[DW-1] && !d_reg[DW-1] && (d_reg != '0));
    assign status.keep       = !d_reg[DW-1];
    assign status.cap_full   = (cnt_reg >= CW'(OUT_CAP));
    assign status.div_busy   = div_busy;
    assign status.comp_last  = (comp_reg == 2'd2);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/hpc_ctrl.sv =====
`timescale 1ns / 1ps

module hpc_ctrl
    import hpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_op_t     op,
    output logic       busy
);

    typedef enum logic [25:0] {
        S_IDLE      = 26'h0000001,
        S_LMUL      = 26'h0000002,
        S_LCODE     = 26'h0000004,
        S_LACC      = 26'h0000008,
        S_CHECK     = 26'h0000010,
        S_PSEL      = 26'h0000020,
        S_PSTART    = 26'h0000040,
        S_RD        = 26'h0000080,
        S_FETCH     = 26'h0000100,
        S_MUL       = 26'h0000200,
        S_DIST      = 26'h0000400,
        S_DEC       = 26'h0000800,
        S_DIVW      = 26'h0001000,
        S_LM        = 26'h0002000,
        S_LA        = 26'h0004000,
        S_WINT      = 26'h0008000,
        S_WCUR      = 26'h0010000,
        S_KNEXT     = 26'h0020000,
        S_PEND      = 26'h0040000,
        S_PCHK      = 26'h0080000,
        S_ERST      = 26'h0100000,
        S_ERD       = 26'h0200000,
        S_EOUT      = 26'h0400000,
        S_EMPTY     = 26'h0800000,
        S_EMPTY_OVF = 26'h1000000,
        S_CLR       = 26'h2000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = S_LMUL;
                end
            end
            S_LMUL:
            begin
                op         = OP_MUL;
                state_next = S_LCODE;
            end
            S_LCODE:
            begin
                op         = OP_CODE;
                state_next = status.plane_last ? S_LACC : S_LMUL;
            end
            S_LACC:
            begin
                op         = OP_ACC;
                state_next = status.final_flag ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                op = OP_PLANE_CLR;
                if (status.ovf_flag)
                    state_next = S_EMPTY_OVF;
                else if (status.degen || status.reject)
                    state_next = S_EMPTY;
                else
                    state_next = S_PSEL;
            end
            S_PSEL:
            begin
                if (status.plane_on)
                    state_next = status.n_lt3 ? S_EMPTY : S_PSTART;
                else if (status.plane_last)
                    state_next = S_ERST;
                else
                    op = OP_PLANE_NEXT;
            end
            S_PSTART:
            begin
                op         = OP_PASS_START;
                state_next = S_RD;
            end
            S_RD:
            begin
                op         = OP_RD;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                op         = OP_FETCH;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                op         = OP_MUL;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                op         = OP_DIST;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (status.k_is0)
                    state_next = S_KNEXT;
                else if (status.crossing)
                begin
                    op         = OP_DIV_START;
                    state_next = S_DIVW;
                end
                else if (status.keep)
                    state_next = S_WCUR;
                else
                    state_next = S_KNEXT;
            end
            S_DIVW:
            begin
                if (!status.div_busy)
                    state_next = S_LM;
            end
            S_LM:
            begin
                op         = OP_LMUL;
                state_next = S_LA;
            end
            S_LA:
            begin
                op         = OP_LADD;
                state_next = status.comp_last ? S_WINT : S_LM;
            end
            S_WINT:
            begin
                if (status.cap_full)
                    state_next = S_EMPTY_OVF;
                else
                begin
                    op         = OP_WR_INT;
                    state_next = status.keep ? S_WCUR : S_KNEXT;
                end
            end
            S_WCUR:
            begin
                if (status.cap_full)
                    state_next = S_EMPTY_OVF;
                else
                begin
                    op         = OP_WR_CUR;
                    state_next = S_KNEXT;
                end
            end
            S_KNEXT:
            begin
                if (status.k_eq_n)
                    state_next = S_PEND;
                else
                begin
                    op         = OP_KINC;
                    state_next = S_RD;
                end
            end
            S_PEND:
            begin
                op         = OP_PASS_END;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (status.n_lt3)
                    state_next = S_EMPTY;
                else if (status.plane_last)
                    state_next = S_ERST;
                else
                begin
                    op         = OP_PLANE_NEXT;
                    state_next = S_PSEL;
                end
            end
            S_ERST:
            begin
                op         = OP_EMIT_START;
                state_next = S_ERD;
            end
            S_ERD:
            begin
                op         = OP_RD;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                op         = OP_EMIT;
                state_next = status.k_last ? S_CLR : S_ERD;
            end
            S_EMPTY:
            begin
                op         = OP_EMPTY;
                state_next = S_CLR;
            end
            S_EMPTY_OVF:
            begin
                op         = OP_EMPTY_OVF;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                op         = OP_CLEAR;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/homogeneous_polygon_clipper_core.sv =====
`timescale 1ns / 1ps

// Polygon clipper for homogeneous (x,y,w) vertices against a pixel rectangle.
// One vertex word is taken when start is high and busy low; busy then stays
// high while the four outcodes are formed one plane at a time (one shared
// 18x32 multiplier). On the vertex marked final the block stays busy until
// the whole polygon is out: every plane that some vertex lies outside costs
// a pass over the stored vertices, and each edge crossing adds the 30-step
// serial divider and the three-step interpolation. Results leave one word
// per store read, each on result for a single cycle with result_valid high;
// the receiver cannot stall them, so it must take every word as it comes.
// The last word of a polygon has run_end set; a rejected, degenerate or
// shrunk polygon gives one word with nothing_left set, and overflow set when
// capacity ran out. The rectangle is to be written through cfg_we/cfg_index/
// cfg_data only while busy is low; the block itself does not enforce it.

module homogeneous_polygon_clipper_core
    import hpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    vertex,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output out_word_t   result
);

    dp_op_t     op;
    dp_status_t status;

    // sequencer: one datapath operation per cycle
    hpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    // distances, divider, interpolation, ping-pong stores, output register
    hpc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .vertex       (vertex),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== hdl/hpc_checker.sv =====
`timescale 1ns / 1ps

module hpc_checker
    import hpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      result_valid,
    input out_word_t result
);

    // words only appear while a polygon is being processed
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result word outside busy");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.nothing_left) |->
            (result.run_end && (result.out_x == 0) && (result.out_y == 0)
             && (result.out_w == 0)))
        else $error("malformed empty marker");

    a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.overflow) |-> result.nothing_left)
        else $error("overflow on a vertex word");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.run_end) |=> !result_valid)
        else $error("word after end of polygon");

endmodule

bind homogeneous_polygon_clipper_core hpc_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Bench for the homogeneous polygon clipper.
// Vertices go in as command words (start/busy). Every accepted vertex is fed to
// a clipping predictor, which queues the words the polygon should give. Output
// words cannot be held off, so the monitor checks each one on the cycle that it
// shows up.

module tb_top;
    import hpc_pkg::*;

    // Clipping predictor plus the store of words still due
    class clip_predictor;
        int         rx_min, rx_max, ry_min, ry_max;
        vtx_t       vstore[2][STORE_DEPTH];
        int         vcount;
        logic [3:0] code_or, code_and;
        bit         ovf;
        out_word_t  due_words[$];
        int         mismatches;

        function new();
            rx_min = RST_X_MIN;
            rx_max = RST_X_MAX;
            ry_min = RST_Y_MIN;
            ry_max = RST_Y_MAX;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            vcount   = 0;
            code_or  = 4'b0000;
            code_and = 4'b1111;
            ovf      = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [15:0] val);
            case (idx)
                REG_X_MIN: rx_min = $signed(val);
                REG_X_MAX: rx_max = $signed(val);
                REG_Y_MIN: ry_min = $signed(val);
                REG_Y_MAX: ry_max = $signed(val);
                default: ;
            endcase
        endfunction

        // Signed distance of v from plane p, in pixel half-units times w
        function longint plane_dist(int p, vtx_t v);
            longint x2, y2, w;
            x2 = 2 * longint'(v.x);
            y2 = 2 * longint'(v.y);
            w  = longint'(v.w);
            case (p)
                0:       return x2 - (2 * longint'(rx_min) - 1) * w;
                1:       return (2 * longint'(rx_max) - 1) * w - x2;
                2:       return y2 - (2 * longint'(ry_min) - 1) * w;
                default: return (2 * longint'(ry_max) - 1) * w - y2;
            endcase
        endfunction

        // Move from cur towards prev by t (30-bit fraction), rounded to nearest, ties away from cur
        function logic [31:0] interp(logic signed [31:0] cur, logic signed [31:0] prev,
                                     longint unsigned t);
            longint          diff;
            longint unsigned mag, r;
            longint          res;
            diff = longint'(prev) - longint'(cur);
            mag  = (diff < 0) ? -diff : diff;
            r    = (mag * t + (64'd1 << (T_BITS - 1))) >> T_BITS;
            res  = (diff < 0) ? longint'(cur) - longint'(r) : longint'(cur) + longint'(r);
            return res[31:0];
        endfunction

        // One plane pass from bank s into the other bank; 0 if capacity is exceeded
        function bit clip_pass(int p, int s, int n, output int m);
            int              cnt, prev_i, i;
            longint          d, dprev, dd;
            longint unsigned num, den, rem, t;
            vtx_t            nv;
            cnt = 0;
            prev_i = 0;
            dprev = 0;
            m = 0;
            for (int k = 0; k <= n; k++) begin
                i = (k == n) ? 0 : k;
                d = plane_dist(p, vstore[s][i]);
                if (k > 0) begin
                    if ((dprev > 0 && d < 0) || (dprev < 0 && d > 0)) begin
                        num = (d < 0) ? -d : d;
                        dd  = d - dprev;
                        den = (dd < 0) ? -dd : dd;
                        rem = num;
                        t   = 0;
                        for (int b = 0; b < T_BITS; b++) begin
                            rem = rem << 1;
                            t   = t << 1;
                            if (rem >= den) begin
                                rem = rem - den;
                                t   = t | 1;
                            end
                        end
                        if (cnt >= OUT_CAP)
                            return 0;
                        nv.x = interp(vstore[s][i].x, vstore[s][prev_i].x, t);
                        nv.y = interp(vstore[s][i].y, vstore[s][prev_i].y, t);
                        nv.w = interp(vstore[s][i].w, vstore[s][prev_i].w, t);
                        vstore[s ^ 1][cnt] = nv;
                        cnt++;
                    end
                    if (d >= 0) begin
                        if (cnt >= OUT_CAP)
                            return 0;
                        vstore[s ^ 1][cnt] = vstore[s][i];
                        cnt++;
                    end
                end
                dprev  = d;
                prev_i = i;
            end
            m = cnt;
            return 1;
        endfunction

        function void push_empty(bit ovf_mark);
            out_word_t e;
            e = '0;
            e.run_end      = 1'b1;
            e.nothing_left = 1'b1;
            e.overflow     = ovf_mark;
            due_words.push_back(e);
            restart();
        endfunction

        function void note_vertex(in_word_t iw);
            vtx_t       v;
            logic [3:0] c;
            int         n, m, sel;
            out_word_t  o;
            v.x = iw.vert_x;
            v.y = iw.vert_y;
            v.w = iw.vert_w;
            if (vcount < IN_CAP) begin
                for (int p = 0; p < 4; p++)
                    c[p] = plane_dist(p, v) < 0;
                vstore[0][vcount] = v;
                vcount++;
                code_or  |= c;
                code_and &= c;
            end else
                ovf = 1;
            if (!iw.final_vertex)
                return;
            if (ovf) begin
                push_empty(1);
                return;
            end
            if (rx_max <= rx_min || ry_max <= ry_min || code_and != 0) begin
                push_empty(0);
                return;
            end
            n = vcount;
            sel = 0;
            for (int p = 0; p < 4; p++) begin
                if (code_or[p]) begin
                    if (n < 3) begin
                        push_empty(0);
                        return;
                    end
                    if (!clip_pass(p, sel, n, m)) begin
                        push_empty(1);
                        return;
                    end
                    n = m;
                    if (n < 3) begin
                        push_empty(0);
                        return;
                    end
                    sel ^= 1;
                end
            end
            for (int k = 0; k < n; k++) begin
                o = '0;
                o.out_x   = vstore[sel][k].x;
                o.out_y   = vstore[sel][k].y;
                o.out_w   = vstore[sel][k].w;
                o.run_end = (k + 1 == n);
                due_words.push_back(o);
            end
            restart();
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (due_words.size() == 0) begin
                $error("result word with nothing due: %h", got);
                mismatches++;
                return;
            end
            exp_w = due_words.pop_front();
            if (got.out_x !== exp_w.out_x) begin
                $error("out_x: expected %h, got %h", exp_w.out_x, got.out_x);
                mismatches++;
            end
            if (got.out_y !== exp_w.out_y) begin
                $error("out_y: expected %h, got %h", exp_w.out_y, got.out_y);
                mismatches++;
            end
            if (got.out_w !== exp_w.out_w) begin
                $error("out_w: expected %h, got %h", exp_w.out_w, got.out_w);
                mismatches++;
            end
            if (got.run_end !== exp_w.run_end) begin
                $error("run_end: expected %b, got %b", exp_w.run_end, got.run_end);
                mismatches++;
            end
            if (got.nothing_left !== exp_w.nothing_left) begin
                $error("nothing_left: expected %b, got %b", exp_w.nothing_left,
                       got.nothing_left);
                mismatches++;
            end
            if (got.overflow !== exp_w.overflow) begin
                $error("overflow: expected %b, got %b", exp_w.overflow, got.overflow);
                mismatches++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_word_t    vertex;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_valid;
    out_word_t   result;

    clip_predictor clipper = new();
    int            burst_left;
    int            vertices_sent;
    longint        cycles;

    homogeneous_polygon_clipper_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vertex       (vertex),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Output words cannot be stalled: check every one as it passes
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            clipper.check_word(result);
    end

    // Send one vertex word. The sender runs in bursts; between bursts start
    // drops for a random gap. start stays high from word to word inside a burst.
    task automatic send_word(in_word_t w);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        start  <= 1'b1;
        vertex <= w;
        do
            @(posedge clk);
        while (busy);
        clipper.note_vertex(w);
        vertices_sent++;
        burst_left--;
        if (burst_left == 0)
            start <= 1'b0;
    endtask

    // Registers change only with the block idle and every due word out
    task automatic write_rect(logic [15:0] x0, logic [15:0] x1,
                              logic [15:0] y0, logic [15:0] y1);
        logic [15:0] vals[4];
        vals = '{x0, x1, y0, y1};
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (busy || clipper.due_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_e'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            clipper.set_reg(cfg_reg_e'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic in_word_t mk_word(longint x, longint y, longint w, bit last);
        in_word_t r;
        r.vert_x       = x[31:0];
        r.vert_y       = y[31:0];
        r.vert_w       = w[31:0];
        r.final_vertex = last;
        return r;
    endfunction

    // Vertex near the current rectangle, mostly; sometimes pure noise
    function automatic in_word_t rand_word(bit last);
        longint span_x, span_y, px, py, w;
        if ($urandom_range(0, 19) == 0)
            return mk_word($urandom, $urandom, $urandom, last);
        span_x = clipper.rx_max - clipper.rx_min;
        span_y = clipper.ry_max - clipper.ry_min;
        if (span_x < 4)
            span_x = 4;
        if (span_y < 4)
            span_y = 4;
        px = clipper.rx_min - span_x / 2 + $urandom_range(0, 2 * span_x);
        py = clipper.ry_min - span_y / 2 + $urandom_range(0, 2 * span_y);
        w  = longint'($urandom_range(1, 2048)) << $urandom_range(0, 6);
        if ($urandom_range(0, 19) == 0)
            w = -w;
        return mk_word(px * w + $urandom_range(0, 3), py * w, w, last);
    endfunction

    task automatic send_polygon(int n);
        for (int i = 0; i < n; i++)
            send_word(rand_word(i == n - 1));
    endtask

    int n_verts;
    int x0;

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        vertex     = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_X_MIN;
        cfg_data   = '0;
        burst_left = 0;
        vertices_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset rectangle: triangle fully inside (unchanged)
        send_word(mk_word(100 <<< 16, 100 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(300 <<< 16, 50 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(200 <<< 16, 400 <<< 16, 1 <<< 16, 1));
        // lone inside vertex is passed through
        send_word(mk_word(10 <<< 16, 10 <<< 16, 1 <<< 16, 1));
        // two vertices that need clipping give an empty word
        send_word(mk_word(-50 <<< 16, 10 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(50 <<< 16, 10 <<< 16, 1 <<< 16, 1));
        // quad crossing all four planes
        send_word(mk_word(-100 <<< 16, -100 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(900 <<< 16, -100 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(900 <<< 16, 700 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(-100 <<< 16, 700 <<< 16, 1 <<< 16, 1));
        // trivial reject, everything left of the rectangle
        send_word(mk_word(-10 <<< 16, 5 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(-20 <<< 16, 50 <<< 16, 1 <<< 16, 0));
        send_word(mk_word(-30 <<< 16, 9 <<< 16, 1 <<< 16, 1));
        // field extremes, negative and zero weight
        send_word(mk_word(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
        send_word(mk_word(32'h80000000, 32'h7fffffff, 32'hffffffff, 0));
        send_word(mk_word(0, 0, 32'h80000000, 0));
        send_word(mk_word(0, 0, 0, 1));

        // widest rectangle, then a degenerate one each way
        write_rect(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_polygon(4);
        send_word(mk_word(32'h7fffffff, 32'h80000000, 1, 0));
        send_word(mk_word(32'h80000000, 32'h7fffffff, 1, 0));
        send_word(mk_word(5, 5, 32'hffff0000, 1));
        write_rect(16'd100, 16'd100, 16'd0, 16'd480);
        send_polygon(3);
        write_rect(16'd0, 16'd640, 16'd50, 16'hffce);
        send_polygon(3);

        // Random part: fresh rectangle every so often, polygons of mixed size.
        // Over-long ones run out of input capacity.
        while (vertices_sent < 420)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: write_rect(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
                    1: write_rect(16'hfff6, 16'd10, 16'hfffb, 16'd5);
                    2: write_rect(16'd0, 16'd640, 16'd0, 16'd480);
                    default:
                    begin
                        x0 = $urandom_range(0, 4000) - 2000;
                        write_rect(16'(x0), 16'(x0 + $urandom_range(1, 3000)),
                                   16'(x0 - $urandom_range(0, 500)),
                                   16'(x0 + $urandom_range(1, 2000)));
                    end
                endcase
            end
            case ($urandom_range(0, 9))
                0:       n_verts = $urandom_range(1, 2);
                1:       n_verts = $urandom_range(IN_CAP - 1, IN_CAP + 3);
                default: n_verts = $urandom_range(3, 8);
            endcase
            send_polygon(n_verts);
        end

        start <= 1'b0;
        while (clipper.due_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (clipper.mismatches == 0 && clipper.due_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hpc_pkg.sv
hdl/hpc_div.sv
hdl/hpc_datapath.sv
hdl/hpc_ctrl.sv
hdl/homogeneous_polygon_clipper_core.sv
hdl/hpc_checker.sv
sim/tb_top.sv
